// ===== rtl/core/jhsh_pkg.sv =====
// ----------------------------------------------------------------------------
// JPEG Huffman symbol histogram package
// Shared widths, codes, memory operation types and the category function.
// ----------------------------------------------------------------------------
package jhsh_pkg;

  localparam int COEF_W       = 16;
  localparam int BIN_W        = 8;
  localparam int COUNT_PORT_W = 32;
  localparam int STRIDE_W     = 9;
  localparam int POS_W        = 6;
  localparam int PHASE_W      = 8;
  localparam int CAT_W        = 5;
  localparam int AC_DEPTH     = 256;
  localparam int DC_DEPTH     = 16;
  localparam int DC_IDX_W     = 4;
  localparam int AMOUNT_W     = 2;

  localparam logic [BIN_W-1:0]    ZRL_BIN      = 8'hF0;
  localparam logic [BIN_W-1:0]    EOB_BIN      = 8'h00;
  localparam logic [POS_W-1:0]    BLOCK_LAST   = 6'd63;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd16;
  localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 9'd256;

  typedef enum logic [1:0] {
    ACT_COEF    = 2'd0,
    ACT_READ_DC = 2'd1,
    ACT_READ_AC = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic                valid;
    op_kind_t            kind;
    logic                dc;
    logic [BIN_W-1:0]    addr;
    logic [AMOUNT_W-1:0] amount;
  } hist_op_t;

  typedef struct packed {
    logic                    read_pending;
    logic [COUNT_PORT_W-1:0] rd_count;
  } hist_status_t;

  // Bit-length category of a two's complement value; the most negative
  // value yields category sixteen.
  function automatic logic [CAT_W-1:0] category(input logic [COEF_W-1:0] raw);
    logic [COEF_W-1:0] mag;
    logic [CAT_W-1:0]  cat;
    mag = raw[COEF_W-1] ? (~raw + 1'b1) : raw;
    cat = '0;
    for (int i = 0; i < COEF_W; i++) begin
      if (mag[i]) begin
        cat = CAT_W'(i + 1);
      end
    end
    return cat;
  endfunction

endpackage

// ===== rtl/core/jhsh_if.sv =====
// ----------------------------------------------------------------------------
// JPEG Huffman symbol histogram channels
// Request channel (action, coefficient, bin index) and count response channel.
// ----------------------------------------------------------------------------
interface jhsh_req_if import jhsh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic signed [COEF_W-1:0] coefficient;
  logic [BIN_W-1:0]         bin_index;

  modport source (output valid, output action, output coefficient, output bin_index,
                  input ready);
  modport sink (input valid, input action, input coefficient, input bin_index,
                output ready);
endinterface

interface jhsh_rsp_if import jhsh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COUNT_PORT_W-1:0] count;

  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

// ===== rtl/core/jhsh_hist.sv =====
// ----------------------------------------------------------------------------
// JPEG Huffman symbol histogram store
// AC and DC count memories with registered reads, valid flags for fast clear,
// and a read-modify-write stage with forwarding of the last write.
// ----------------------------------------------------------------------------
module jhsh_hist import jhsh_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  hist_op_t     issue,
  output hist_status_t status
);

  logic [COUNT_WIDTH-1:0] ac_mem [AC_DEPTH];
  logic [COUNT_WIDTH-1:0] dc_mem [DC_DEPTH];
  logic [COUNT_WIDTH-1:0] ac_q;
  logic [COUNT_WIDTH-1:0] dc_q;
  logic [AC_DEPTH-1:0]    ac_valid;
  logic [DC_DEPTH-1:0]    dc_valid;
  hist_op_t               s2;

  logic                   last_valid;
  logic                   last_dc;
  logic [BIN_W-1:0]       last_addr;
  logic [COUNT_WIDTH-1:0] last_data;

  logic [DC_IDX_W-1:0]    s2_dc_idx;
  logic [COUNT_WIDTH-1:0] stored;
  logic [COUNT_WIDTH-1:0] current;
  logic [COUNT_WIDTH-1:0] sum;
  logic                   fwd;
  logic                   wr_en;
  logic                   clr;

  always_comb begin
    s2_dc_idx = s2.addr[DC_IDX_W-1:0];
    if (s2.dc) begin
      stored = dc_valid[s2_dc_idx] ? dc_q : '0;
    end else begin
      stored = ac_valid[s2.addr] ? ac_q : '0;
    end
    fwd     = last_valid && (last_dc == s2.dc) && (last_addr == s2.addr);
    current = fwd ? last_data : stored;
    sum     = current + COUNT_WIDTH'(s2.amount);
    wr_en   = s2.valid && (s2.kind == OP_ADD);
    clr     = s2.valid && (s2.kind == OP_CLEAR);
  end

  assign status.read_pending = s2.valid && (s2.kind == OP_READ);
  assign status.rd_count     = COUNT_PORT_W'(current);

  always_ff @(posedge clk) begin
    if (adv) begin
      ac_q <= ac_mem[issue.addr];
      dc_q <= dc_mem[issue.addr[DC_IDX_W-1:0]];
    end
    if (wr_en && !s2.dc) begin
      ac_mem[s2.addr] <= sum;
    end
    if (wr_en && s2.dc) begin
      dc_mem[s2_dc_idx] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_dc   <= s2.dc;
      last_addr <= s2.addr;
      last_data <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2         <= '0;
      ac_valid   <= '0;
      dc_valid   <= '0;
      last_valid <= 1'b0;
    end else begin
      if (adv) begin
        s2 <= issue;
      end
      if (clr) begin
        ac_valid   <= '0;
        dc_valid   <= '0;
        last_valid <= 1'b0;
      end else if (wr_en) begin
        last_valid <= 1'b1;
        if (s2.dc) begin
          dc_valid[s2_dc_idx] <= 1'b1;
        end else begin
          ac_valid[s2.addr] <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/jpeg_huffman_symbol_histogram_top.sv =====
// ----------------------------------------------------------------------------
// JPEG Huffman symbol histogram
// Counts DC categories and AC run/size, ZRL and EOB symbols of sampled blocks.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    action, coefficient, bin_index
//   rsp      out  valid/ready    count
//   cfg      in   cfg_we         cfg_wdata (sample_stride)
//
// A request is taken every cycle unless stalled, except a counted nonzero AC
// coefficient after sixteen or more zeros, which is held while its ZRL update issues:
// its ZRL and symbol updates share the single read-modify-write path of the AC memory.
// A read request's count is registered in the histogram stage and then in the count
// register before it is presented on the response channel.
// Reset and the clear request empty all bins at once through valid flags.
// The request side also stalls while a held response blocks a pending read.
// ----------------------------------------------------------------------------
module jpeg_huffman_symbol_histogram_top import jhsh_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [STRIDE_W-1:0] cfg_wdata,
  jhsh_req_if.sink            req,
  jhsh_rsp_if.source          rsp
);

  logic [STRIDE_W-1:0]     sample_stride;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        pos_next;
  logic [POS_W-1:0]        run;
  logic [POS_W-1:0]        run_next;
  logic [PHASE_W-1:0]      block_phase;
  logic [PHASE_W-1:0]      block_phase_next;
  logic                    second;
  logic                    rsp_valid;
  logic                    rsp_valid_next;
  logic [COUNT_PORT_W-1:0] count_q;

  hist_op_t                issue;
  hist_status_t            status;

  logic                    counted;
  logic [CAT_W-1:0]        cat;
  logic [DC_IDX_W-1:0]     cat_ac;
  logic                    coef_zero;
  logic                    at_first;
  logic                    at_last;
  logic                    two_ops;
  logic                    adv;
  logic                    accept;
  logic                    coef_accept;
  logic [STRIDE_W-1:0]     eff_stride;
  logic [STRIDE_W-1:0]     phase_inc;

  jhsh_hist #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .issue  (issue),
    .status (status)
  );

  always_comb begin
    counted   = (block_phase == '0);
    cat       = category(req.coefficient);
    cat_ac    = cat[CAT_W-1] ? '1 : cat[DC_IDX_W-1:0];
    coef_zero = (req.coefficient == '0);
    at_first  = (pos == '0);
    at_last   = (pos == BLOCK_LAST);
    two_ops   = (req.action == ACT_COEF) && !at_first && !coef_zero && counted &&
                (run[POS_W-1:4] != '0);
    adv       = !status.read_pending || !rsp_valid || rsp.ready;
    req.ready = adv && (!two_ops || second);
    accept    = req.valid && req.ready;
    coef_accept = accept && (req.action == ACT_COEF);

    issue = '0;
    if (req.valid && adv) begin
      unique case (req.action)
        ACT_READ_DC: begin
          issue.valid = 1'b1;
          issue.kind  = OP_READ;
          issue.dc    = 1'b1;
          issue.addr  = BIN_W'(req.bin_index[DC_IDX_W-1:0]);
        end
        ACT_READ_AC: begin
          issue.valid = 1'b1;
          issue.kind  = OP_READ;
          issue.addr  = req.bin_index;
        end
        ACT_CLEAR: begin
          issue.valid = 1'b1;
          issue.kind  = OP_CLEAR;
        end
        ACT_COEF: begin
          issue.kind   = OP_ADD;
          issue.amount = AMOUNT_W'(1);
          if (at_first) begin
            issue.valid = counted && !cat[CAT_W-1];
            issue.dc    = 1'b1;
            issue.addr  = BIN_W'(cat[DC_IDX_W-1:0]);
          end else if (coef_zero) begin
            issue.valid = counted && at_last;
            issue.addr  = EOB_BIN;
          end else if (two_ops && !second) begin
            issue.valid  = 1'b1;
            issue.addr   = ZRL_BIN;
            issue.amount = run[POS_W-1:4];
          end else begin
            issue.valid = counted;
            issue.addr  = {run[3:0], cat_ac};
          end
        end
        default: issue = '0;
      endcase
    end

    if (sample_stride == '0) begin
      eff_stride = STRIDE_W'(1);
    end else if (sample_stride > STRIDE_MAX) begin
      eff_stride = STRIDE_MAX;
    end else begin
      eff_stride = sample_stride;
    end
    phase_inc = STRIDE_W'(block_phase) + 1'b1;

    pos_next         = pos;
    run_next         = run;
    block_phase_next = block_phase;
    if (coef_accept) begin
      if (at_first || !coef_zero) begin
        run_next = '0;
      end else begin
        run_next = run + 1'b1;
      end
      if (at_last) begin
        pos_next         = '0;
        run_next         = '0;
        block_phase_next = (phase_inc >= eff_stride) ? '0 : phase_inc[PHASE_W-1:0];
      end else begin
        pos_next = pos + 1'b1;
      end
    end

    rsp_valid_next = (rsp_valid && !rsp.ready) || (status.read_pending && adv);
  end

  assign rsp.valid = rsp_valid;
  assign rsp.count = count_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_stride <= STRIDE_RESET;
      pos           <= '0;
      run           <= '0;
      block_phase   <= '0;
      second        <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        sample_stride <= cfg_wdata;
      end
      pos         <= pos_next;
      run         <= run_next;
      block_phase <= block_phase_next;
      rsp_valid   <= rsp_valid_next;
      if (accept) begin
        second <= 1'b0;
      end else if (req.valid && adv && two_ops && !second) begin
        second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status.read_pending && adv) begin
      count_q <= status.rd_count;
    end
  end

  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    (coef_accept && at_last) |=> (pos == '0) && (run == '0))
    else $error("block position or zero run not restarted after last coefficient");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (coef_accept && at_last) |=> (STRIDE_W'(block_phase) < $past(eff_stride)))
    else $error("block phase outside sampling stride");

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    (status.read_pending && rsp_valid && !rsp.ready) |=> status.read_pending)
    else $error("pending read lost while response stalled");

  a_second_half: assert property (@(posedge clk) disable iff (rst)
    $rose(second) |-> $past(req.valid && two_ops && adv))
    else $error("second update phase without a two-update request");

endmodule
